>>> hdl/sfd_pkg.sv
// shared types and constants for the serial frame deframer
`default_nettype none

package sfd_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_START_MARKER = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_END_MARKER   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_LIMIT    = 2'd2;

    localparam logic [7:0]  START_MARKER_RST = 8'd2;
    localparam logic [7:0]  END_MARKER_RST   = 8'd3;
    localparam logic [15:0] GAP_LIMIT_RST    = 16'd50;

    localparam logic [3:0] POS_CLOSE    = 4'd15;
    localparam logic [3:0] POS_PAYLOAD  = 4'd7;
    localparam logic [3:0] POS_LENGTH   = 4'd6;
    localparam logic [3:0] POS_REMOTE   = 4'd5;
    localparam logic [3:0] POS_EXTENDED = 4'd4;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [15:0] TICKS_MAX = 16'hffff;

    typedef struct packed {
        logic [7:0]  start_marker;
        logic [7:0]  end_marker;
        logic [15:0] gap_limit;
    } t_cfg;

endpackage

`default_nettype wire

>>> hdl/sfd_cfg_regs.sv
// configuration register file for the serial frame deframer
`default_nettype none

module sfd_cfg_regs
    import sfd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                        o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker <= START_MARKER_RST;
            r_cfg.end_marker   <= END_MARKER_RST;
            r_cfg.gap_limit    <= GAP_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_START_MARKER: r_cfg.start_marker <= i_cfg_data[7:0];
                REG_END_MARKER:   r_cfg.end_marker   <= i_cfg_data[7:0];
                REG_GAP_LIMIT:    r_cfg.gap_limit    <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/sfd_core.sv
// frame state update and result register
`default_nettype none

module sfd_core
    import sfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_in_valid,
    input  wire logic        i_op,
    input  wire logic [7:0]  i_byte,
    output logic             o_take,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_identifier,
    output logic [7:0]       o_extended_byte,
    output logic [7:0]       o_remote_byte,
    output logic [7:0]       o_length_byte,
    output logic [63:0]      o_payload
);

    logic        r_frame, n_frame;
    logic [3:0]  r_pos, n_pos;
    logic [15:0] r_elapsed, n_elapsed;
    logic [31:0] r_ident, n_ident;
    logic [7:0]  r_ext, n_ext;
    logic [7:0]  r_rtr, n_rtr;
    logic [7:0]  r_len, n_len;
    logic [63:0] r_pl, n_pl;
    logic        r_out_valid;
    logic        emit;
    logic        live;
    logic [3:0]  pl_off;

    assign o_take = i_in_valid && (!r_out_valid || !i_stall);
    assign live   = r_frame && (r_elapsed <= i_cfg.gap_limit);
    assign pl_off = r_pos - POS_PAYLOAD;

    always_comb begin
        n_frame   = r_frame;
        n_pos     = r_pos;
        n_elapsed = r_elapsed;
        n_ident   = r_ident;
        n_ext     = r_ext;
        n_rtr     = r_rtr;
        n_len     = r_len;
        n_pl      = r_pl;
        emit      = 1'b0;
        if (i_op == OP_TICK) begin
            if (r_elapsed != TICKS_MAX) begin
                n_elapsed = r_elapsed + 16'd1;
            end
        end else if (live) begin
            n_elapsed = '0;
            if (r_pos == POS_CLOSE) begin
                n_frame = 1'b0;
                emit    = (i_byte == i_cfg.end_marker);
            end else begin
                if (r_pos >= POS_PAYLOAD) begin
                    n_pl[pl_off[2:0]*8 +: 8] = i_byte;
                end else if (r_pos == POS_LENGTH) begin
                    n_len = i_byte;
                end else if (r_pos == POS_REMOTE) begin
                    n_rtr = i_byte;
                end else if (r_pos == POS_EXTENDED) begin
                    n_ext = i_byte;
                end else begin
                    n_ident[r_pos[1:0]*8 +: 8] = i_byte;
                end
                n_pos = r_pos + 4'd1;
            end
        end else begin
            n_frame = 1'b0;
            if (i_byte == i_cfg.start_marker) begin
                n_frame   = 1'b1;
                n_elapsed = '0;
                n_pos     = '0;
                n_ident   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame     <= 1'b0;
            r_pos       <= '0;
            r_elapsed   <= '0;
            r_ident     <= '0;
            r_ext       <= '0;
            r_rtr       <= '0;
            r_len       <= '0;
            r_pl        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_frame     <= n_frame;
                r_pos       <= n_pos;
                r_elapsed   <= n_elapsed;
                r_ident     <= n_ident;
                r_ext       <= n_ext;
                r_rtr       <= n_rtr;
                r_len       <= n_len;
                r_pl        <= n_pl;
                r_out_valid <= emit;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && emit) begin
            o_identifier    <= r_ident;
            o_extended_byte <= r_ext;
            o_remote_byte   <= r_rtr;
            o_length_byte   <= r_len;
            o_payload       <= r_pl;
        end
    end

    assign o_valid = r_out_valid;

    a_result_from_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_frame))
        else $error("result without open frame");

    a_close_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_op == OP_BYTE && live && r_pos == POS_CLOSE) |=> !r_frame)
        else $error("frame still open after closing byte");

    a_tick_keeps_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_op == OP_TICK) |=> (r_frame == $past(r_frame)) && !r_out_valid)
        else $error("tick changed frame state or gave a result");

    a_tick_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_op == OP_TICK && r_elapsed == TICKS_MAX) |=> r_elapsed == TICKS_MAX)
        else $error("tick counter wrapped");

endmodule

`default_nettype wire

>>> hdl/serial_frame_to_message_deframer.sv
// top level of the serial frame deframer
//
// input channel: i_valid / o_stall carry one request, either a received byte
// (i_op low, value on i_rx_byte) or one timer tick (i_op high).
// output channel: o_valid / i_stall carry one assembled message.
// config channel: i_cfg_valid / o_cfg_ready with register index and data;
// index 0 start marker, 1 end marker, 2 gap limit in ticks.
// a request is caught in an input register, then the frame state and the
// result register update when the core takes it: a message is driven from
// the result register, which loads as its closing byte is taken.
// throughput is one request per cycle while no message waits under i_stall;
// the state update is a single register write per request.
// while a finished message waits under i_stall the input register still
// takes one request; further requests are stalled until the message goes.
// reset (i_rst_n low, synchronous) closes any frame, clears the tick count
// and the held fields, and loads the marker and gap defaults.
`default_nettype none

module serial_frame_to_message_deframer
    import sfd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic                   i_op,
    input  wire logic [7:0]             i_rx_byte,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [31:0]                 o_identifier,
    output logic [7:0]                  o_extended_byte,
    output logic [7:0]                  o_remote_byte,
    output logic [7:0]                  o_length_byte,
    output logic [63:0]                 o_payload,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg       cfg;
    logic       r_in_valid;
    logic       r_op;
    logic [7:0] r_byte;
    logic       take;

    assign o_stall = r_in_valid && !take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_op   <= i_op;
            r_byte <= i_rx_byte;
        end
    end

    sfd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sfd_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_in_valid      (r_in_valid),
        .i_op            (r_op),
        .i_byte          (r_byte),
        .o_take          (take),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_identifier    (o_identifier),
        .o_extended_byte (o_extended_byte),
        .o_remote_byte   (o_remote_byte),
        .o_length_byte   (o_length_byte),
        .o_payload       (o_payload)
    );

endmodule

`default_nettype wire

>>> bench/tb_serial_frame_to_message_deframer.sv
// testbench for the serial frame deframer: directed and random frames checked against a predictor
`timescale 1ns / 100ps

module tb_serial_frame_to_message_deframer;
    import sfd_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int RANDOM_MSGS   = 40;
    localparam int LONG_TICKS    = 200;

    typedef struct packed {
        logic [31:0] identifier;
        logic [7:0]  extended_byte;
        logic [7:0]  remote_byte;
        logic [7:0]  length_byte;
        logic [63:0] payload;
    } t_msg;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic                   i_op;
    logic [7:0]             i_rx_byte;
    logic                   o_valid;
    logic                   i_stall;
    logic [31:0]            o_identifier;
    logic [7:0]             o_extended_byte;
    logic [7:0]             o_remote_byte;
    logic [7:0]             o_length_byte;
    logic [63:0]            o_payload;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    serial_frame_to_message_deframer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_identifier    (o_identifier),
        .o_extended_byte (o_extended_byte),
        .o_remote_byte   (o_remote_byte),
        .o_length_byte   (o_length_byte),
        .o_payload       (o_payload),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // predicted deframer state and settings
    logic [7:0]  want_start   = START_MARKER_RST;
    logic [7:0]  want_end     = END_MARKER_RST;
    logic [15:0] want_gap     = GAP_LIMIT_RST;
    logic        frame_open   = 1'b0;
    logic [3:0]  frame_pos    = '0;
    logic [15:0] tick_count   = '0;
    logic [31:0] ident_bytes  = '0;
    logic [7:0]  ext_byte     = '0;
    logic [7:0]  rtr_byte     = '0;
    logic [7:0]  len_byte     = '0;
    logic [63:0] payload_bytes = '0;

    t_msg pending_msgs[$];
    int   error_count   = 0;
    int   msgs_received = 0;
    int   requests_sent = 0;
    bit   sender_gaps   = 1'b1;
    bit   stall_enable  = 1'b1;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic track_request(input logic op, input logic [7:0] b);
        int   shift;
        t_msg m;
        if (op == OP_TICK) begin
            if (tick_count != TICKS_MAX)
                tick_count = tick_count + 16'd1;
        end else begin
            if (frame_open && tick_count > want_gap)
                frame_open = 1'b0;
            if (frame_open) begin
                tick_count = '0;
                if (frame_pos >= POS_CLOSE) begin
                    frame_open = 1'b0;
                    if (b == want_end) begin
                        m.identifier    = ident_bytes;
                        m.extended_byte = ext_byte;
                        m.remote_byte   = rtr_byte;
                        m.length_byte   = len_byte;
                        m.payload       = payload_bytes;
                        pending_msgs.push_back(m);
                    end
                end else begin
                    if (frame_pos >= POS_PAYLOAD) begin
                        shift = (int'(frame_pos) - int'(POS_PAYLOAD)) * 8;
                        payload_bytes[shift +: 8] = b;
                    end else if (frame_pos >= POS_LENGTH) begin
                        len_byte = b;
                    end else if (frame_pos >= POS_REMOTE) begin
                        rtr_byte = b;
                    end else if (frame_pos >= POS_EXTENDED) begin
                        ext_byte = b;
                    end else begin
                        shift = int'(frame_pos) * 8;
                        ident_bytes[shift +: 8] = b;
                    end
                    frame_pos = frame_pos + 4'd1;
                end
            end else if (b == want_start) begin
                frame_open  = 1'b1;
                tick_count  = '0;
                frame_pos   = '0;
                ident_bytes = '0;
            end
        end
    endtask

    function automatic int pick_gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        else if (r < 93)
            return $urandom_range(3, 1);
        else
            return $urandom_range(24, 8);
    endfunction

    task automatic send_request(input logic op, input logic [7:0] b);
        int gap;
        gap = sender_gaps ? pick_gap_len() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_op      <= op;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        track_request(op, b);
        requests_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_request(OP_TICK, 8'($urandom));
    endtask

    // sender pauses until every predicted message is out and the pipeline is quiet
    task automatic wait_until_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_msgs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_START_MARKER: want_start = data[7:0];
            REG_END_MARKER:   want_end   = data[7:0];
            REG_GAP_LIMIT:    want_gap   = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_markers(input logic [7:0] s, input logic [7:0] e);
        write_reg(REG_START_MARKER, {8'($urandom), s});
        write_reg(REG_END_MARKER, {8'($urandom), e});
    endtask

    function automatic int pick_tick_count();
        int r;
        int span;
        r = $urandom_range(99);
        span = (want_gap > 16'd6) ? 6 : ((want_gap == 16'd0) ? 1 : int'(want_gap));
        if (r < 72)
            return 0;
        else if (r < 92)
            return $urandom_range(span, 1);
        else if (want_gap <= 16'd40)
            return int'(want_gap) + ((r < 96) ? 0 : 1);
        else
            return 0;
    endfunction

    function automatic logic [7:0] pick_data_byte();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return want_start;
        else if (r < 16)
            return want_end;
        else if (r < 20)
            return 8'h00;
        else if (r < 24)
            return 8'hff;
        else
            return 8'($urandom);
    endfunction

    task automatic send_frame(input bit with_ticks, input bit good_close, input int body_len);
        logic [7:0] closer;
        if (with_ticks)
            send_ticks(pick_tick_count());
        send_request(OP_BYTE, want_start);
        for (int i = 0; i < body_len; i++) begin
            if (with_ticks)
                send_ticks(pick_tick_count());
            send_request(OP_BYTE, pick_data_byte());
        end
        if (body_len == 15) begin
            if (with_ticks)
                send_ticks(pick_tick_count());
            closer = want_end;
            if (!good_close) begin
                closer = 8'($urandom);
                if (closer == want_end)
                    closer = ~want_end;
            end
            send_request(OP_BYTE, closer);
        end
    endtask

    task automatic test_default_frame();
        logic [7:0] body[15] = '{8'hff, 8'h00, 8'h02, 8'h80, 8'h01, 8'hff, 8'h08,
                                 8'h02, 8'h03, 8'h00, 8'hff, 8'h55, 8'haa, 8'h7f, 8'h81};
        send_request(OP_BYTE, 8'h00);
        send_request(OP_BYTE, 8'hff);
        send_request(OP_BYTE, END_MARKER_RST);
        send_request(OP_TICK, 8'ha5);
        send_request(OP_BYTE, START_MARKER_RST);
        foreach (body[i])
            send_request(OP_BYTE, body[i]);
        send_request(OP_BYTE, END_MARKER_RST);
        wait_until_drained();
    endtask

    task automatic test_wrong_close();
        send_frame(1'b0, 1'b0, 15);
        send_frame(1'b1, 1'b1, 15);
        wait_until_drained();
    endtask

    task automatic test_gap_timeout();
        send_request(OP_BYTE, want_start);
        send_request(OP_BYTE, 8'h11);
        send_ticks(int'(want_gap));
        send_request(OP_BYTE, 8'h22);
        send_ticks(int'(want_gap) + 1);
        send_request(OP_BYTE, 8'h77);
        send_request(OP_BYTE, want_start);
        send_ticks(int'(want_gap) + 1);
        send_frame(1'b0, 1'b1, 15);
        wait_until_drained();
    endtask

    task automatic test_marker_extremes();
        set_markers(8'h00, 8'hff);
        send_frame(1'b1, 1'b1, 15);
        send_frame(1'b1, 1'b0, 15);
        wait_until_drained();
        set_markers(8'hff, 8'h00);
        send_frame(1'b1, 1'b1, 15);
        send_frame(1'b0, 1'b0, 15);
        wait_until_drained();
        set_markers(8'h5a, 8'h5a);
        send_frame(1'b0, 1'b1, 15);
        send_frame(1'b1, 1'b1, 15);
        wait_until_drained();
    endtask

    task automatic test_gap_extremes();
        set_markers(START_MARKER_RST, END_MARKER_RST);
        write_reg(REG_GAP_LIMIT, 16'h0000);
        send_request(OP_BYTE, want_start);
        send_request(OP_TICK, 8'h00);
        send_request(OP_BYTE, want_start);
        send_frame(1'b0, 1'b1, 15);
        wait_until_drained();
        // full-scale gap limit keeps the frame open over a long run of ticks
        write_reg(REG_GAP_LIMIT, 16'hffff);
        send_request(OP_BYTE, want_start);
        send_request(OP_BYTE, 8'h3c);
        sender_gaps = 1'b0;
        send_ticks(LONG_TICKS);
        sender_gaps = 1'b1;
        for (int i = 0; i < 14; i++)
            send_request(OP_BYTE, pick_data_byte());
        send_request(OP_BYTE, want_end);
        wait_until_drained();
    endtask

    task automatic test_bad_index();
        write_reg(REG_UNUSED, 16'($urandom));
        write_reg(REG_GAP_LIMIT, GAP_LIMIT_RST);
        send_frame(1'b1, 1'b1, 15);
        wait_until_drained();
    endtask

    function automatic logic [7:0] pick_marker();
        int r;
        r = $urandom_range(99);
        if (r < 20)
            return 8'h00;
        else if (r < 40)
            return 8'hff;
        else
            return 8'($urandom);
    endfunction

    function automatic logic [15:0] pick_gap_limit();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return 16'h0000;
        else if (r < 30)
            return 16'hffff;
        else if (r < 55)
            return 16'($urandom_range(4, 1));
        else if (r < 90)
            return 16'($urandom_range(30, 5));
        else
            return 16'($urandom);
    endfunction

    task automatic test_random();
        int start_count;
        int seq_count;
        int r;
        start_count = requests_sent;
        while (requests_sent - start_count < RANDOM_ITEMS || msgs_received < RANDOM_MSGS) begin
            wait_until_drained();
            set_markers(pick_marker(), pick_marker());
            write_reg(REG_GAP_LIMIT, pick_gap_limit());
            sender_gaps  = ($urandom_range(4) != 0);
            stall_enable = ($urandom_range(4) != 0);
            seq_count = $urandom_range(8, 2);
            repeat (seq_count) begin
                r = $urandom_range(99);
                if (r < 70) begin
                    send_frame(1'b1, 1'b1, 15);
                end else if (r < 80) begin
                    send_frame(1'b1, 1'b0, 15);
                end else if (r < 88) begin
                    send_frame(1'b1, 1'b1, $urandom_range(14, 0));
                end else begin
                    repeat ($urandom_range(5, 1)) begin
                        if ($urandom_range(1))
                            send_request(OP_TICK, 8'($urandom));
                        else
                            send_request(OP_BYTE, 8'($urandom));
                    end
                end
            end
        end
        sender_gaps  = 1'b1;
        stall_enable = 1'b1;
        wait_until_drained();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_op        = OP_BYTE;
        i_rx_byte   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_default_frame();
        test_wrong_close();
        test_gap_timeout();
        test_marker_extremes();
        test_gap_extremes();
        test_bad_index();
        test_random();
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // receiver back-pressure in runs of random length
    initial begin : stall_driver
        int  run_left;
        bit  stalled;
        int  r;
        run_left = 0;
        stalled  = 1'b0;
        i_stall  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (run_left == 0) begin
                stalled = stall_enable && ($urandom_range(2) == 0);
                r = $urandom_range(99);
                if (!stalled)
                    run_left = $urandom_range(6, 1);
                else if (r < 70)
                    run_left = $urandom_range(2, 1);
                else if (r < 95)
                    run_left = $urandom_range(6, 3);
                else
                    run_left = $urandom_range(40, 15);
            end
            run_left--;
            i_stall <= stalled;
        end
    end

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_messages
        t_msg want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_msgs.size() == 0) begin
                error_count++;
                $display("%0t: message expected none, got id %h payload %h",
                         $time, o_identifier, o_payload);
            end else begin
                want = pending_msgs.pop_front();
                msgs_received++;
                compare_field("identifier", 64'(want.identifier), 64'(o_identifier));
                compare_field("extended_byte", 64'(want.extended_byte), 64'(o_extended_byte));
                compare_field("remote_byte", 64'(want.remote_byte), 64'(o_remote_byte));
                compare_field("length_byte", 64'(want.length_byte), 64'(o_length_byte));
                compare_field("payload", want.payload, o_payload);
            end
        end
    end

    initial begin
        #20000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
